FILE: design/shf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shf_pkg
// Shared types for the streaming string hash: input beat and stage hand-off.
// ----------------------------------------------------------------------------
package shf_pkg;

  // one input beat as held in the input register
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] string_length;
    logic        last_byte;
  } shf_beat_t;

  // pre-avalanche hash handed from the mixing stage to the final stage
  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } shf_pre_t;

endpackage

FILE: design/shf_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shf_mix
// Input register, running hash state, four-byte mixing round and tail rule.
// ----------------------------------------------------------------------------
module shf_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  shf_pkg::shf_beat_t in_beat,
  output shf_pkg::shf_pre_t  pre,
  input  logic              pre_take
);
  import shf_pkg::*;

  // sign-extend one byte to 32 bits
  function automatic logic [31:0] sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  // one mixing round over two little-endian 16-bit words
  function automatic logic [31:0] mix_round(input logic [31:0] acc,
                                            input logic [15:0] w0,
                                            input logic [15:0] w1);
    logic [31:0] h;
    logic [31:0] t;
    h = acc + {16'd0, w0};
    t = ({16'd0, w1} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    mix_round = h;
  endfunction

  // leftover bytes of an unfinished group
  function automatic logic [31:0] tail_mix(input logic [31:0] acc,
                                           input logic [23:0] hb,
                                           input logic [1:0]  hc);
    logic [31:0] h;
    h = acc;
    case (hc)
      2'd3: begin
        h = h + {16'd0, hb[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(hb[23:16]) << 18);
        h = h + (h >> 11);
      end
      2'd2: begin
        h = h + {16'd0, hb[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      2'd1: begin
        h = h + sext8(hb[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = acc;
      end
    endcase
    tail_mix = h;
  endfunction

  // input register
  logic      beat_valid;
  shf_beat_t beat;

  // running state
  logic [31:0] hash_acc;
  logic [23:0] held_bytes;
  logic [1:0]  held_count;
  logic        in_string;

  logic [31:0] hash_acc_next;
  logic [23:0] held_bytes_next;
  logic [1:0]  held_count_next;
  logic        in_string_next;

  logic [31:0] acc_cur;
  logic [23:0] hb_cur;
  logic [1:0]  hc_cur;
  logic [31:0] acc_upd;
  logic [23:0] hb_upd;
  logic [1:0]  hc_upd;
  logic        zero_len;
  logic        want_result;
  logic [31:0] result_value;
  logic        pre_room;
  logic        consume;

  // pre-avalanche result register
  logic        pre_valid;
  logic [31:0] pre_value;

  // mixing and tail logic for the beat in the input register
  always_comb begin
    zero_len = (beat.string_length == 32'd0);
    acc_cur  = in_string ? hash_acc   : beat.string_length;
    hb_cur   = in_string ? held_bytes : 24'd0;
    hc_cur   = in_string ? held_count : 2'd0;
    if (hc_cur == 2'd3) begin
      acc_upd = mix_round(acc_cur, hb_cur[15:0], {beat.data_byte, hb_cur[23:16]});
      hb_upd  = 24'd0;
      hc_upd  = 2'd0;
    end else begin
      acc_upd = acc_cur;
      hb_upd  = hb_cur;
      case (hc_cur)
        2'd0:    hb_upd[7:0]   = beat.data_byte;
        2'd1:    hb_upd[15:8]  = beat.data_byte;
        2'd2:    hb_upd[23:16] = beat.data_byte;
        default: hb_upd        = hb_cur;
      endcase
      hc_upd = hc_cur + 2'd1;
    end
    want_result = zero_len || beat.last_byte;
    // a closed group leaves nothing for the tail rule
    if (zero_len)
      result_value = 32'd0;
    else if (hc_cur == 2'd3)
      result_value = acc_upd;
    else
      result_value = tail_mix(acc_cur, hb_upd, hc_upd);
    if (want_result) begin
      hash_acc_next   = 32'd0;
      held_bytes_next = 24'd0;
      held_count_next = 2'd0;
      in_string_next  = 1'b0;
    end else begin
      hash_acc_next   = acc_upd;
      held_bytes_next = hb_upd;
      held_count_next = hc_upd;
      in_string_next  = 1'b1;
    end
  end

  // stage flow: a beat is used up when its result, if any, has room
  assign pre_room = !pre.valid || pre_take;
  assign consume  = beat_valid && (!want_result || pre_room);
  assign in_stall = beat_valid && !consume;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beat <= in_beat;
    end
  end

  // running state update
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc   <= 32'd0;
      held_bytes <= 24'd0;
      held_count <= 2'd0;
      in_string  <= 1'b0;
    end else if (consume) begin
      hash_acc   <= hash_acc_next;
      held_bytes <= held_bytes_next;
      held_count <= held_count_next;
      in_string  <= in_string_next;
    end
  end

  // pre-avalanche result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (pre_room) begin
      pre_valid <= consume && want_result;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_room && consume && want_result) begin
      pre_value <= result_value;
    end
  end

  assign pre = {pre_valid, pre_value};

  // a held result does not change until taken
  a_pre_hold: assert property (@(posedge clk) disable iff (rst)
    pre.valid && !pre_take |=> pre.valid && $stable(pre.value))
    else $error("pre-avalanche result changed while held");

  // the last byte ends the string
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    consume && beat.last_byte |=> !in_string && held_count == 2'd0)
    else $error("string state survived the last byte");

  // held bytes only exist inside a string
  a_held_in_string: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> in_string)
    else $error("held bytes outside a string");

  // an empty string yields zero on the next cycle
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    consume && zero_len |=> pre.valid && pre.value == 32'd0)
    else $error("empty string did not give zero");

endmodule

FILE: design/shf_avalanche.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shf_avalanche
// Final avalanche rule and the output register of the hash channel.
// ----------------------------------------------------------------------------
module shf_avalanche (
  input  logic              clk,
  input  logic              rst,
  input  shf_pkg::shf_pre_t  pre,
  output logic              pre_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       hash_value
);
  import shf_pkg::*;

  logic [31:0] hash_next;

  // avalanche shifts and adds
  always_comb begin
    hash_next = pre.value;
    hash_next = hash_next ^ (hash_next << 3);
    hash_next = hash_next + (hash_next >> 5);
    hash_next = hash_next ^ (hash_next << 4);
    hash_next = hash_next + (hash_next >> 17);
    hash_next = hash_next ^ (hash_next << 25);
    hash_next = hash_next + (hash_next >> 6);
  end

  // output register frees up when empty or when its beat leaves
  assign pre_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pre_take) begin
      out_valid <= pre.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_take && pre.valid) begin
      hash_value <= hash_next;
    end
  end

endmodule

FILE: design/superfast_string_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superfast_string_hash_top
// Streaming 32-bit string hash, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one string byte per cycle while in_stall is low, with no gaps
// between strings. A beat passes an input register, then the mixing logic
// that updates the running hash (this state update sets the byte rate),
// then the pre-avalanche register, the avalanche stage and the output
// register, where hash_value appears for the beat carrying last_byte, or a
// beat with a zero string_length, which returns 0 and drops any string in
// progress. string_length seeds the hash on the first byte of each string
// only. Stalls on the output back up through the stages; input beats keep
// flowing while finished hashes wait, until two are held and a third has
// nowhere to go.
module superfast_string_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [31:0] string_length,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);
  import shf_pkg::*;

  shf_beat_t in_beat;
  shf_pre_t  pre;
  logic      pre_take;

  // gather input fields into one beat
  assign in_beat = {data_byte, string_length, last_byte};

  // mixing stage
  shf_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .pre      (pre),
    .pre_take (pre_take)
  );

  // avalanche and output stage
  shf_avalanche u_avalanche (
    .clk        (clk),
    .rst        (rst),
    .pre        (pre),
    .pre_take   (pre_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule
